// ----- design/priority_round_robin_scheduler_top_defines.svh -----
// Assertion macros shared by the scheduler's checker.
// No dependencies; included by file name where assertions are written.
`ifndef PRIORITY_ROUND_ROBIN_SCHEDULER_TOP_DEFINES_SVH
`define PRIORITY_ROUND_ROBIN_SCHEDULER_TOP_DEFINES_SVH

// Same-cycle implication, reset-qualified.
`define PRRS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scheduler check failed");

// Next-cycle implication, reset-qualified.
`define PRRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scheduler check failed");

`endif

// ----- design/prrs_pkg.sv -----
// Shared types and constants for the priority round-robin scheduler.
// No dependencies.
package prrs_pkg;

	localparam int MAX_PROCS_DEF = 16;
	localparam int ID_W          = 4;
	localparam int PRIO_W        = 8;
	localparam int KIND_W        = 2;
	localparam int COUNT_W       = 5;
	localparam int ENTRY_W       = ID_W + PRIO_W;
	localparam int DATA_W        = 16;
	localparam int IN_USER_W     = KIND_W;
	localparam int OUT_USER_W    = 2;

	// Request kinds
	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SCHED  = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE, ST_INSERT, ST_DELETE, ST_SCHED, ST_MIN, ST_NEXT, ST_MOVE, ST_POP, ST_RESULT
	} prrs_state_t;

	// Scan operations over the ready list
	typedef enum logic [1:0] {OP_MIN, OP_NEXT, OP_MOVE, OP_DEL} prrs_op_t;

	typedef struct packed {
		logic     load_item;
		logic     scan_start;
		prrs_op_t scan_op;
		logic     swap;
		logic     do_insert;
		logic     pop;
		logic     finish;
	} prrs_cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              scan_busy;
		logic              rr_empty;
		logic              ready_empty;
		logic              out_free;
	} prrs_status_t;

endpackage

// ----- design/prrs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module prrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- design/prrs_datapath.sv -----
// Datapath: ready-list banks, round-robin list, scan engine, result register.
// Depends on prrs_pkg and prrs_ram.
module prrs_datapath #(
	parameter int MAX_PROCS = prrs_pkg::MAX_PROCS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  prrs_pkg::prrs_cmd_t              cmd,
	output prrs_pkg::prrs_status_t           status,
	input  logic [prrs_pkg::DATA_W-1:0]      s_tdata,
	input  logic [prrs_pkg::IN_USER_W-1:0]   s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [prrs_pkg::DATA_W-1:0]      m_tdata,
	output logic [prrs_pkg::OUT_USER_W-1:0]  m_tuser
);
	import prrs_pkg::*;

	localparam int IW = $clog2(MAX_PROCS);
	localparam int LW = $clog2(MAX_PROCS + 1);
	localparam logic [LW-1:0] LEN_FULL = LW'(MAX_PROCS);
	localparam logic [LW-1:0] ONE      = LW'(1);

	// captured request
	logic [KIND_W-1:0] kind_q;
	logic [ID_W-1:0]   pid_q;
	logic [PRIO_W-1:0] prio_q;

	// list state
	logic [LW-1:0]     ready_len_q, rr_len_q;
	logic              bank_q;
	logic [PRIO_W-1:0] least_q, next_q;
	logic              has_next_q;
	logic [IW-1:0]     nidx_q;
	logic [LW-1:0]     cnt_q, wr_k_q;
	logic              found_q, pop_q, drop_q;
	prrs_op_t          op_q;

	// scan engine
	logic [LW-1:0] rd_idx_q;
	logic          scan_on_q;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;

	// result register
	logic              out_vld_q;
	logic [ID_W-1:0]   out_id_q;
	logic              out_idle_q, out_drop_q;
	logic [COUNT_W-1:0] out_cnt_q;

	// memories
	logic               we0, we1, rr_we, mv_we;
	logic [IW-1:0]      wa0, wa1, mv_addr, rr_raddr;
	logic [ENTRY_W-1:0] wd0, wd1, rd0, rd1, ent;
	logic [ID_W-1:0]    rr_rdata;
	logic [PRIO_W-1:0]  e_prio;
	logic [ID_W-1:0]    e_id;
	logic               full;

	assign ent    = bank_q ? rd1 : rd0;
	assign e_prio = ent[ENTRY_W-1:ID_W];
	assign e_id   = ent[ID_W-1:0];
	assign full   = (ready_len_q == LEN_FULL);

	// move/delete write into the other bank
	always_comb begin
		mv_we   = 1'b0;
		mv_addr = wr_k_q[IW-1:0];
		rr_we   = 1'b0;
		if (vld_s1 && op_q == OP_MOVE) begin
			mv_we = 1'b1;
			if (e_prio == least_q) begin
				mv_addr = IW'(ready_len_q - cnt_q + rr_len_q);
				rr_we   = 1'b1;
			end else if (has_next_q && idx_s1 == nidx_q) begin
				mv_addr = IW'(ready_len_q - cnt_q - ONE);
			end
		end else if (vld_s1 && op_q == OP_DEL) begin
			mv_we = !(!found_q && e_id == pid_q);
		end
	end

	// bank port steering: insert goes to current bank, rebuilds to the other
	always_comb begin
		logic ins;
		ins = cmd.do_insert && !full;
		we0 = (ins && !bank_q) || (mv_we && bank_q);
		we1 = (ins && bank_q) || (mv_we && !bank_q);
		wa0 = ins ? ready_len_q[IW-1:0] : mv_addr;
		wa1 = wa0;
		wd0 = ins ? {prio_q, pid_q} : ent;
		wd1 = wd0;
	end

	assign rr_raddr = cmd.pop ? IW'(rr_len_q - ONE) : rr_len_q[IW-1:0];

	prrs_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_PROCS)) u_bank0 (
		.clk(clk), .we(we0), .waddr(wa0), .wdata(wd0),
		.raddr(rd_idx_q[IW-1:0]), .rdata(rd0)
	);
	prrs_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_PROCS)) u_bank1 (
		.clk(clk), .we(we1), .waddr(wa1), .wdata(wd1),
		.raddr(rd_idx_q[IW-1:0]), .rdata(rd1)
	);
	prrs_ram #(.WIDTH(ID_W), .DEPTH(MAX_PROCS)) u_rr (
		.clk(clk), .we(rr_we), .waddr(rr_len_q[IW-1:0]), .wdata(e_id),
		.raddr(rr_raddr), .rdata(rr_rdata)
	);

	// request capture (kind, id and priority; no reset)
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q <= s_tuser[KIND_W-1:0];
			pid_q  <= s_tdata[ID_W-1:0];
			prio_q <= s_tdata[ENTRY_W-1:ID_W];
		end
	end

	// scan address generator; vld_s1 and idx_s1 follow the registered RAM read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q  <= '0;
			scan_on_q <= 1'b0;
			vld_s1    <= 1'b0;
			idx_s1    <= '0;
			op_q      <= OP_MIN;
		end else begin
			vld_s1 <= scan_on_q;
			idx_s1 <= rd_idx_q[IW-1:0];
			if (cmd.scan_start) begin
				rd_idx_q  <= '0;
				scan_on_q <= (ready_len_q != '0);
				op_q      <= cmd.scan_op;
			end else if (scan_on_q) begin
				rd_idx_q <= rd_idx_q + ONE;
				if (rd_idx_q == ready_len_q - ONE) begin
					scan_on_q <= 1'b0;
				end
			end
		end
	end

	// list bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_len_q <= '0;
			rr_len_q    <= '0;
			bank_q      <= 1'b0;
			has_next_q  <= 1'b0;
			cnt_q       <= '0;
			wr_k_q      <= '0;
			found_q     <= 1'b0;
			pop_q       <= 1'b0;
			drop_q      <= 1'b0;
			least_q     <= '0;
			next_q      <= '0;
			nidx_q      <= '0;
		end else begin
			if (cmd.load_item) begin
				pop_q  <= 1'b0;
				drop_q <= 1'b0;
			end
			if (cmd.do_insert) begin
				if (full) begin
					drop_q <= 1'b1;
				end else begin
					ready_len_q <= ready_len_q + ONE;
				end
			end
			if (cmd.scan_start) begin
				wr_k_q  <= '0;
				found_q <= 1'b0;
				if (cmd.scan_op == OP_NEXT) begin
					has_next_q <= 1'b0;
					cnt_q      <= '0;
				end
			end
			// per-entry scan work
			if (vld_s1) begin
				case (op_q)
					OP_MIN: begin
						if (idx_s1 == '0 || e_prio < least_q) begin
							least_q <= e_prio;
						end
					end
					OP_NEXT: begin
						if (e_prio == least_q) begin
							cnt_q <= cnt_q + ONE;
						end else if (!has_next_q || e_prio < next_q) begin
							next_q     <= e_prio;
							nidx_q     <= idx_s1;
							has_next_q <= 1'b1;
						end
					end
					OP_MOVE: begin
						if (e_prio == least_q) begin
							rr_len_q <= rr_len_q + ONE;
						end else if (!(has_next_q && idx_s1 == nidx_q)) begin
							wr_k_q <= wr_k_q + ONE;
						end
					end
					OP_DEL: begin
						if (!found_q && e_id == pid_q) begin
							found_q <= 1'b1;
						end else begin
							wr_k_q <= wr_k_q + ONE;
						end
					end
					default: ;
				endcase
			end
			if (cmd.swap) begin
				bank_q <= !bank_q;
				if (op_q == OP_DEL && found_q) begin
					ready_len_q <= ready_len_q - ONE;
				end
			end
			if (cmd.pop) begin
				rr_len_q <= rr_len_q - ONE;
				pop_q    <= 1'b1;
			end
		end
	end

	// result register, decouples the output side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.finish) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_id_q   <= pop_q ? rr_rdata : '0;
			out_idle_q <= (kind_q == KIND_SCHED) && !pop_q;
			out_drop_q <= drop_q;
			out_cnt_q  <= COUNT_W'(ready_len_q);
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = DATA_W'({out_cnt_q, out_id_q});
	assign m_tuser  = {out_drop_q, out_idle_q};

	assign status.kind        = kind_q;
	assign status.scan_busy   = scan_on_q || vld_s1;
	assign status.rr_empty    = (rr_len_q == '0);
	assign status.ready_empty = (ready_len_q == '0);
	assign status.out_free    = !out_vld_q || m_tready;
endmodule

// ----- design/prrs_ctrl.sv -----
// Controller state machine sequencing insert, delete and schedule work.
// Depends on prrs_pkg.
module prrs_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic [prrs_pkg::KIND_W-1:0] s_kind,
	output logic                   s_tready,
	input  prrs_pkg::prrs_status_t status,
	output prrs_pkg::prrs_cmd_t    cmd
);
	import prrs_pkg::*;

	prrs_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_item = 1'b1;
					case (s_kind)
						KIND_INSERT: state_d = ST_INSERT;
						KIND_DELETE: begin
							cmd.scan_start = 1'b1;
							cmd.scan_op    = OP_DEL;
							state_d        = ST_DELETE;
						end
						KIND_SCHED:  state_d = ST_SCHED;
						default:     state_d = ST_RESULT;
					endcase
				end
			end
			ST_INSERT: begin
				cmd.do_insert = 1'b1;
				state_d       = ST_RESULT;
			end
			ST_DELETE: begin
				if (!status.scan_busy) begin
					cmd.swap = 1'b1;
					state_d  = ST_RESULT;
				end
			end
			ST_SCHED: begin
				if (!status.rr_empty) begin
					state_d = ST_POP;
				end else if (status.ready_empty) begin
					state_d = ST_RESULT;
				end else begin
					cmd.scan_start = 1'b1;
					cmd.scan_op    = OP_MIN;
					state_d        = ST_MIN;
				end
			end
			ST_MIN: begin
				if (!status.scan_busy) begin
					cmd.scan_start = 1'b1;
					cmd.scan_op    = OP_NEXT;
					state_d        = ST_NEXT;
				end
			end
			ST_NEXT: begin
				if (!status.scan_busy) begin
					cmd.scan_start = 1'b1;
					cmd.scan_op    = OP_MOVE;
					state_d        = ST_MOVE;
				end
			end
			ST_MOVE: begin
				if (!status.scan_busy) begin
					cmd.swap = 1'b1;
					state_d  = ST_POP;
				end
			end
			ST_POP: begin
				cmd.pop = 1'b1;
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

// ----- design/priority_round_robin_scheduler_top.sv -----
// Priority scheduler with round-robin among equal priorities.
// Delete scans the ready list once. Schedule with a queued id pops it; a refill
// runs three ready-list scans through the banked RAM read port. One item at a time.
// Asynchronous active-low reset empties both lists and the result register.
module priority_round_robin_scheduler_top #(
	parameter int MAX_PROCS = prrs_pkg::MAX_PROCS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [prrs_pkg::DATA_W-1:0]      s_tdata,  // proc_id[3:0], prio[11:4]
	input  logic [prrs_pkg::IN_USER_W-1:0]   s_tuser,  // kind[1:0]
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [prrs_pkg::DATA_W-1:0]      m_tdata,  // running_id[3:0], ready_count[8:4]
	output logic [prrs_pkg::OUT_USER_W-1:0]  m_tuser   // idle[0], dropped[1]
);
	import prrs_pkg::*;

	prrs_cmd_t    cmd;
	prrs_status_t status;

	prrs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_kind(s_tuser[KIND_W-1:0]), .s_tready(s_tready),
		.status(status), .cmd(cmd)
	);

	prrs_datapath #(.MAX_PROCS(MAX_PROCS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);
endmodule

// ----- design/prrs_checker.sv -----
// Port-level checker for the scheduler, bound to the top level.
// Depends on prrs_pkg and the assertion macro header.
`include "priority_round_robin_scheduler_top_defines.svh"
module prrs_checker #(
	parameter int MAX_PROCS = prrs_pkg::MAX_PROCS_DEF
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [prrs_pkg::DATA_W-1:0]     m_tdata,
	input logic [prrs_pkg::OUT_USER_W-1:0] m_tuser
);
	import prrs_pkg::*;

	localparam logic [COUNT_W-1:0] CNT_MAX = COUNT_W'(MAX_PROCS);

	// a stalled result stays offered
	`PRRS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	// count never exceeds the list depth
	`PRRS_ASSERT_NOW(a_count_max, clk, arst_n, m_tvalid, m_tdata[8:4] <= CNT_MAX || MAX_PROCS > 31)
	// idle and dropped never together
	`PRRS_ASSERT_NOW(a_flags_excl, clk, arst_n, m_tvalid, !(m_tuser[0] && m_tuser[1]))
	// idle result reports id zero
	`PRRS_ASSERT_NOW(a_idle_id, clk, arst_n, m_tvalid && m_tuser[0], m_tdata[3:0] == '0)
	// an accepted item is not followed by another in the next cycle
	`PRRS_ASSERT_NEXT(a_one_at_time, clk, arst_n, s_tvalid && s_tready, !s_tready)
endmodule

bind priority_round_robin_scheduler_top prrs_checker #(.MAX_PROCS(MAX_PROCS)) u_prrs_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

// ----- tb/priority_round_robin_scheduler_checker.sv -----
// Scoreboard for the priority round-robin scheduler: watches both stream channels,
// predicts each result from accepted requests and compares. Depends on prrs_pkg.
`timescale 1ns / 1ps
module priority_round_robin_scheduler_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic [prrs_pkg::DATA_W-1:0]       s_tdata,
	input  logic [prrs_pkg::IN_USER_W-1:0]    s_tuser,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [prrs_pkg::DATA_W-1:0]       m_tdata,
	input  logic [prrs_pkg::OUT_USER_W-1:0]   m_tuser,
	output int                                fail_count,
	output int                                pending
);
	import prrs_pkg::*;

	typedef struct packed {
		logic [3:0] running_id;
		logic       idle;
		logic       dropped;
		logic [4:0] ready_count;
	} sched_result_t;

	// predictor state
	logic [3:0] rdy_id [16];
	logic [7:0] rdy_pr [16];
	int         rdy_n;
	logic [3:0] rr_q [16];
	int         rr_n;
	sched_result_t results_due[$];

	initial begin
		fail_count = 0;
		rdy_n = 0;
		rr_n = 0;
	end

	assign pending = results_due.size();

	// refill round-robin list with the most urgent entries, rotate ready list
	function automatic void refill_rr();
		logic [3:0] nid [16];
		logic [7:0] npr [16];
		int least, nxt, nidx, k;
		bit has_nxt;
		rr_n = 0;
		k = 0;
		nxt = 256;
		nidx = 0;
		has_nxt = 0;
		if (rdy_n == 0) return;
		least = rdy_pr[0];
		for (int i = 1; i < rdy_n; i++) if (rdy_pr[i] < least) least = rdy_pr[i];
		for (int i = 0; i < rdy_n; i++)
			if (rdy_pr[i] != least && rdy_pr[i] < nxt) begin
				nxt = rdy_pr[i];
				nidx = i;
				has_nxt = 1;
			end
		for (int i = 0; i < rdy_n; i++) begin
			if (rdy_pr[i] == least) begin
				rr_q[rr_n] = rdy_id[i];
				rr_n++;
			end else if (!(has_nxt && i == nidx)) begin
				nid[k] = rdy_id[i];
				npr[k] = rdy_pr[i];
				k++;
			end
		end
		if (has_nxt) begin
			nid[k] = rdy_id[nidx];
			npr[k] = rdy_pr[nidx];
			k++;
		end
		for (int i = 0; i < rr_n; i++) begin
			nid[k] = rr_q[i];
			npr[k] = least[7:0];
			k++;
		end
		for (int i = 0; i < rdy_n; i++) begin
			rdy_id[i] = nid[i];
			rdy_pr[i] = npr[i];
		end
	endfunction

	function automatic sched_result_t predict_request(logic [1:0] kind, logic [3:0] pid,
			logic [7:0] pr);
		sched_result_t r;
		r = '0;
		if (kind == KIND_INSERT) begin
			if (rdy_n >= 16) r.dropped = 1'b1;
			else begin
				rdy_id[rdy_n] = pid;
				rdy_pr[rdy_n] = pr;
				rdy_n++;
			end
		end else if (kind == KIND_DELETE) begin
			for (int i = 0; i < rdy_n; i++)
				if (rdy_id[i] == pid) begin
					for (int j = i; j + 1 < rdy_n; j++) begin
						rdy_id[j] = rdy_id[j + 1];
						rdy_pr[j] = rdy_pr[j + 1];
					end
					rdy_n--;
					break;
				end
		end else if (kind == KIND_SCHED) begin
			if (rr_n == 0) refill_rr();
			if (rr_n == 0) r.idle = 1'b1;
			else begin
				rr_n--;
				r.running_id = rr_q[rr_n];
			end
		end
		r.ready_count = rdy_n[4:0];
		return r;
	endfunction

	// request transfers feed the predictor, result transfers are compared
	always @(posedge clk) begin
		sched_result_t exp_r, got;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				results_due.push_back(predict_request(s_tuser, s_tdata[3:0], s_tdata[11:4]));
			if (m_tvalid && m_tready) begin
				got.running_id  = m_tdata[3:0];
				got.ready_count = m_tdata[8:4];
				got.idle        = m_tuser[0];
				got.dropped     = m_tuser[1];
				if (results_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) $display("unexpected result transfer %h", got);
				end else begin
					exp_r = results_due.pop_front();
					if (got !== exp_r || m_tdata[15:9] !== '0) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"mismatch: exp id=%0d idle=%0b drop=%0b cnt=%0d,",
								" got id=%0d idle=%0b drop=%0b cnt=%0d"},
								exp_r.running_id, exp_r.idle, exp_r.dropped,
								exp_r.ready_count, got.running_id, got.idle,
								got.dropped, got.ready_count);
					end
				end
			end
		end
	end
endmodule

// ----- tb/priority_round_robin_scheduler_top_tb.sv -----
// Stimulus and verdict for the priority round-robin scheduler.
// Depends on prrs_pkg, the scheduler top and priority_round_robin_scheduler_checker.
`timescale 1ns / 1ps
module priority_round_robin_scheduler_top_tb;
	import prrs_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [DATA_W-1:0]     s_tdata = '0;
	logic [IN_USER_W-1:0]  s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [DATA_W-1:0]     m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;
	int                    fail_count;
	int                    pending;
	int                    cycles = 0;
	int                    send_idle_pct = 0;
	int                    recv_stall_pct = 0;
	int                    hold_off = 0;

	always #1 clk = ~clk;

	priority_round_robin_scheduler_top uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	priority_round_robin_scheduler_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.fail_count(fail_count), .pending(pending)
	);

	// receiver: random stalls, or a long hold-off when requested
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 1'b0;
		end else
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL priority_round_robin_scheduler_top");
			$finish;
		end
	end

	// offer one request and wait for its transfer; valid stays up until the
	// next request or a drain takes it down
	task automatic send_request(logic [1:0] kind, logic [3:0] pid, logic [7:0] pr);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {4'b0, pr, pid};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// insert, delete, schedule and kind 3 mix; priorities mostly from a small set so ties happen
	task automatic random_request();
		int sel;
		logic [1:0] k;
		sel = $urandom_range(99);
		if (sel < 40) k = KIND_INSERT;
		else if (sel < 60) k = KIND_DELETE;
		else if (sel < 97) k = KIND_SCHED;
		else k = 2'd3;
		if ($urandom_range(3) == 0)
			send_request(k, 4'($urandom_range(15)), 8'($urandom_range(255)));
		else
			send_request(k, 4'($urandom_range(15)), 8'($urandom_range(3) * 85));
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle schedule, extremes, ties, full list, absent delete, kind 3
		send_request(KIND_SCHED, 4'd0, 8'd0);
		send_request(KIND_INSERT, 4'd15, 8'd255);
		send_request(KIND_INSERT, 4'd0, 8'd0);
		send_request(KIND_INSERT, 4'd5, 8'd0);
		send_request(KIND_INSERT, 4'd9, 8'd7);
		send_request(KIND_SCHED, 4'd0, 8'd0);
		send_request(KIND_DELETE, 4'd0, 8'd0);
		send_request(KIND_SCHED, 4'd0, 8'd0);
		send_request(KIND_DELETE, 4'd3, 8'd0);
		send_request(2'd3, 4'd15, 8'd255);
		for (int i = 0; i < 14; i++) send_request(KIND_INSERT, i[3:0], 8'hAA);
		send_request(KIND_SCHED, 4'd0, 8'd0);
		drain();

		// random phases: none, sender idle, receiver stall, both
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = (ph == 1 || ph == 3) ? 86 : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? 86 : 0;
			for (int n = 0; n < 400; n++) random_request();
			drain();
		end

		// back-pressure: receiver holds off while requests keep coming
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off = 300;
		for (int n = 0; n < 50; n++) random_request();
		drain();
		repeat (100) @(posedge clk);

		if (fail_count == 0)
			$display("PASS priority_round_robin_scheduler_top");
		else
			$display("FAIL priority_round_robin_scheduler_top");
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+design
design/prrs_pkg.sv
design/prrs_ram.sv
design/prrs_datapath.sv
design/prrs_ctrl.sv
design/priority_round_robin_scheduler_top.sv
design/prrs_checker.sv
tb/priority_round_robin_scheduler_checker.sv
tb/priority_round_robin_scheduler_top_tb.sv
